// ----- hw/rtl/dsdw_pkg.sv -----
package dsdw_pkg;

    localparam int DIGITS  = 6;
    localparam int VALUE_W = 31;
    localparam int ROW_W   = 24;
    localparam int ROWS    = 4;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int STORE_W = (BCD_W > ROW_W) ? BCD_W : ROW_W;
    localparam int STEPS   = 8;
    localparam int STAGES  = (VALUE_W + STEPS - 1) / STEPS;
    localparam int PAD_W   = STAGES * STEPS;

    typedef logic [BCD_W-1:0]   t_bcd;
    typedef logic [DIGITS-1:0]  t_mask;
    typedef logic [PAD_W-1:0]   t_pad;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [STORE_W-1:0] t_row;
    typedef logic [3:0]         t_nib;
    typedef logic [STEPS-1:0]   t_chunk;

    function automatic logic [31:0] pow10(int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++) begin
            p = 32'(p * 32'd10);
        end
        return p;
    endfunction

    // one shift-add-3 step; digits above the top position are dropped
    function automatic t_bcd dd_shift(t_bcd b, logic din);
        t_bcd a;
        for (int i = 0; i < DIGITS; i++) begin
            a[4*i +: 4] = (b[4*i +: 4] >= 4'd5) ? 4'(b[4*i +: 4] + 4'd3) : b[4*i +: 4];
        end
        return {a[BCD_W-2:0], din};
    endfunction

    function automatic t_bcd dd_chunk(t_bcd b, t_chunk bits);
        t_bcd acc;
        acc = b;
        for (int s = 0; s < STEPS; s++) begin
            acc = dd_shift(acc, bits[STEPS-1-s]);
        end
        return acc;
    endfunction

    // bit i set when decimal digit i lies at or below the most significant nonzero digit
    function automatic t_mask digit_mask(t_value v);
        t_mask m;
        for (int i = 0; i < DIGITS; i++) begin
            m[i] = (32'(v) >= pow10(i));
        end
        return m;
    endfunction

    function automatic t_nib seg_nib(t_nib digit, logic [1:0] row);
        logic [15:0] e;
        case (digit)
            4'd0:    e = 16'h1551;
            4'd1:    e = 16'h0110;
            4'd2:    e = 16'h11E1;
            4'd3:    e = 16'h11B1;
            4'd4:    e = 16'h05B0;
            4'd5:    e = 16'h14B1;
            4'd6:    e = 16'h14F1;
            4'd7:    e = 16'h1110;
            4'd8:    e = 16'h15F1;
            4'd9:    e = 16'h15B1;
            default: e = 16'h0000;
        endcase
        return e[15 - 4*row -: 4];
    endfunction

    function automatic logic bcd_ok(t_bcd b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ----- hw/rtl/decimal_segment_display_writer_top.sv -----
// Writes the six lowest decimal digits of i_value, right-aligned, into four 24-bit
// segment rows and returns all four rows once per input transfer. One item is taken
// every cycle when the output side does not stall. The binary-to-decimal converter is a
// pipeline of four stages that each shift in eight input bits. Conversion stops at the
// most significant nonzero digit: positions to its left keep their earlier contents,
// and a value of zero leaves the rows unchanged. The rows reset to zero, all segments
// off. A stall on the output holds the pipeline back and stalls the input in turn.
module decimal_segment_display_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [30:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_row0,
    output logic [23:0] o_row1,
    output logic [23:0] o_row2,
    output logic [23:0] o_row3
);

    localparam int NS = dsdw_pkg::STAGES;

    logic [NS:0]            r_v;
    logic                   r_ov;
    dsdw_pkg::t_value       r_val [0:NS-1];
    dsdw_pkg::t_bcd         r_bcd [1:NS];
    dsdw_pkg::t_mask        r_msk [1:NS];
    dsdw_pkg::t_row         r_row [0:dsdw_pkg::ROWS-1];

    dsdw_pkg::t_bcd         c_src [1:NS];
    dsdw_pkg::t_pad         c_pad [1:NS];
    dsdw_pkg::t_bcd         n_bcd [1:NS];
    dsdw_pkg::t_mask        n_msk [1:NS];
    dsdw_pkg::t_row         n_row [0:dsdw_pkg::ROWS-1];
    logic [NS:0]            c_rdy;
    logic                   c_rdy_out;

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        if (k == 1) begin : g_first
            assign c_src[k] = '0;
            assign n_msk[k] = dsdw_pkg::digit_mask(r_val[k-1]);
        end else begin : g_next
            assign c_src[k] = r_bcd[k-1];
            assign n_msk[k] = r_msk[k-1];
        end
        assign c_pad[k] = dsdw_pkg::t_pad'(r_val[k-1]);
        assign n_bcd[k] = dsdw_pkg::dd_chunk(c_src[k],
            c_pad[k][dsdw_pkg::PAD_W-1-dsdw_pkg::STEPS*(k-1) -: dsdw_pkg::STEPS]);
    end

    always_comb begin
        c_rdy_out = !r_ov || !i_stall;
        c_rdy[NS] = !r_v[NS] || c_rdy_out;
        for (int k = NS - 1; k >= 0; k--) begin
            c_rdy[k] = !r_v[k] || c_rdy[k+1];
        end
    end

    // merge written digits into the held rows
    always_comb begin
        for (int r = 0; r < dsdw_pkg::ROWS; r++) begin
            n_row[r] = r_row[r];
        end
        for (int i = 0; i < dsdw_pkg::DIGITS; i++) begin
            if (r_msk[NS][i]) begin
                for (int r = 0; r < dsdw_pkg::ROWS; r++) begin
                    n_row[r][4*(dsdw_pkg::DIGITS-1-i) +: 4] =
                        dsdw_pkg::seg_nib(r_bcd[NS][4*i +: 4], 2'(r));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
            for (int r = 0; r < dsdw_pkg::ROWS; r++) begin
                r_row[r] <= '0;
            end
        end else begin
            if (c_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= NS; k++) begin
                if (c_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (c_rdy_out) begin
                r_ov <= r_v[NS];
                if (r_v[NS]) begin
                    for (int r = 0; r < dsdw_pkg::ROWS; r++) begin
                        r_row[r] <= n_row[r];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rdy[0]) begin
            r_val[0] <= i_value;
        end
        for (int k = 1; k < NS; k++) begin
            if (c_rdy[k]) begin
                r_val[k] <= r_val[k-1];
            end
        end
        for (int k = 1; k <= NS; k++) begin
            if (c_rdy[k]) begin
                r_bcd[k] <= n_bcd[k];
                r_msk[k] <= n_msk[k];
            end
        end
    end

    assign o_stall = !c_rdy[0];
    assign o_valid = r_ov;
    assign o_row0  = r_row[0][dsdw_pkg::ROW_W-1:0];
    assign o_row1  = r_row[1][dsdw_pkg::ROW_W-1:0];
    assign o_row2  = r_row[2][dsdw_pkg::ROW_W-1:0];
    assign o_row3  = r_row[3][dsdw_pkg::ROW_W-1:0];

    a_zero_keeps_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] && c_rdy_out && (r_msk[NS] == '0) |=>
            $stable(r_row[0]) && $stable(r_row[1]) && $stable(r_row[2]) && $stable(r_row[3]))
        else $error("rows changed on a zero value");

    a_mask_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] |-> ((r_msk[NS] & dsdw_pkg::t_mask'(r_msk[NS] + 1'b1)) == '0))
        else $error("digit write mask has a gap");

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] |-> dsdw_pkg::bcd_ok(r_bcd[NS]))
        else $error("converted digit above nine");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] && r_ov && i_stall |=> r_v[NS] && r_ov)
        else $error("item dropped while output stalled");

endmodule
